[rtl/tlfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tlfa_pkg;
    localparam int FRAME_COUNT      = 1024;
    localparam int WORDS_PER_FRAME  = 512;
    localparam int FRAMES_PER_TABLE = 2;
    localparam int MEM_WORDS        = FRAME_COUNT * WORDS_PER_FRAME;
    localparam int AW               = $clog2(MEM_WORDS);
    localparam int FW               = $clog2(FRAME_COUNT);
    localparam int OW               = $clog2(WORDS_PER_FRAME);
    localparam int EW               = 21;
    localparam int CHUNK            = 32;
    localparam int NCHUNK           = FRAME_COUNT / CHUNK;
    localparam int CW               = $clog2(NCHUNK);
    localparam int BW               = $clog2(CHUNK);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_MARK  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAULT   = 2'd1,
        ST_ERROR   = 2'd2,
        ST_NOSPACE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDWAIT, S_CHECK, S_SCAN, S_SCANWAIT,
        S_SCANBIT, S_MARK, S_WRENTRY, S_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/tlfa_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tlfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [8:0]  segment;
    logic [9:0]  page;
    logic [8:0]  offset;
    logic [18:0] load_address;
    logic signed [19:0] load_value;
    logic [9:0]  frame_number;
    modport source (output valid, cmd, segment, page, offset, load_address, load_value,
                    frame_number, input ready);
    modport sink (input valid, cmd, segment, page, offset, load_address, load_value,
                  frame_number, output ready);
endinterface

interface tlfa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [18:0] physical_address;
    modport source (output valid, status, physical_address, input ready);
    modport sink (input valid, status, physical_address, output ready);
endinterface
`default_nettype wire

[rtl/two_level_translate_with_frame_alloc_unit.sv]
// A load is written at accept; a mark reads its bitmap word and writes it back; a
// translation reads the first-level entry and then the second-level entry.
// Allocation scans the frame bitmap one bit per cycle, pausing to read each 32-frame word;
// a full pass that finds no free run of frames ends with status ST_NOSPACE.
// One transaction at a time; input is ready again the cycle after the result is taken.
// Reset (synchronous, active low) clears word memory and bitmap; no input until it is done.
`timescale 1ns / 1ps
`default_nettype none
module two_level_translate_with_frame_alloc_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tlfa_in_if.sink   i_in,
    tlfa_out_if.source o_out
);
    import tlfa_pkg::*;

    logic [EW-1:0]     mem [MEM_WORDS];
    logic [CHUNK-1:0]  bmap [NCHUNK];

    t_state r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic [1:0]      r_cmd;
    logic [9:0]      r_page;
    logic [8:0]      r_off;
    logic            r_lvl;
    logic [AW-1:0]   r_addr;
    logic [EW-1:0]   r_rdata;
    logic [CHUNK-1:0] r_bword;
    logic [CW-1:0]   r_chunk;
    logic [BW-1:0]   r_bit;
    logic [1:0]      r_run;
    logic [FW-1:0]   r_first;
    logic [FW-1:0]   r_mfr;
    logic [1:0]      r_mleft;
    logic            r_ovalid;
    logic [1:0]      r_ostat;
    logic [AW-1:0]   r_opa;

    logic [1:0]      need;
    logic            bit_free;
    logic [EW-1:0]   e;
    logic [AW-1:0]   ebase;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [EW-1:0]   mem_wd;
    logic            bm_we;
    logic [CW-1:0]   bm_wa;
    logic [CHUNK-1:0] bm_wd;
    logic [FW-1:0]   cur_frame;

    assign need      = r_lvl ? 2'd1 : 2'(FRAMES_PER_TABLE);
    assign bit_free  = !r_bword[r_bit];
    assign e         = r_rdata;
    assign ebase     = e[AW-1:0];
    assign cur_frame = {r_chunk, r_bit};
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.status = r_ostat;
    assign o_out.physical_address = r_opa[18:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
        if (bm_we) begin
            bmap[bm_wa] <= bm_wd;
        end
        r_bword <= bmap[(r_state == S_MARK || r_state == S_IDLE) ? r_mfr[FW-1:BW] : r_chunk];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            S_IDLE:     if (i_in.valid && i_in.ready) begin
                            n_state = (i_in.cmd == CMD_LOAD) ? S_DONE :
                                      (i_in.cmd == CMD_MARK) ? S_MARK : S_RD;
                        end
            S_RD:       n_state = S_RDWAIT;
            S_RDWAIT:   n_state = S_CHECK;
            S_CHECK:    begin
                            if (e == {EW{1'b1}}) n_state = S_DONE;
                            else if (e == '0) begin
                                n_state = (r_cmd == CMD_WRITE) ? S_SCAN : S_DONE;
                            end else n_state = r_lvl ? S_DONE : S_RD;
                        end
            S_SCAN:     n_state = S_SCANWAIT;
            S_SCANWAIT: n_state = S_SCANBIT;
            S_SCANBIT:  begin
                            if (bit_free && (r_run + 2'd1 == need)) n_state = S_MARK;
                            else if (r_bit == BW'(CHUNK - 1)) begin
                                n_state = (r_chunk == CW'(NCHUNK - 1)) ? S_DONE : S_SCAN;
                            end
                        end
            S_MARK:     if (r_mleft == 2'd0) n_state = (r_cmd == CMD_MARK) ? S_DONE : S_WRENTRY;
            S_WRENTRY:  n_state = r_lvl ? S_DONE : S_RD;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = EW'({r_first, OW'(0)});
        bm_we  = 1'b0;
        bm_wa  = r_mfr[FW-1:BW];
        bm_wd  = r_bword | (CHUNK'(1) << r_mfr[BW-1:0]);
        unique case (r_state)
            S_CLEAR:   begin
                           mem_we = 1'b1;
                           mem_wa = r_clr;
                           mem_wd = '0;
                           bm_we  = 1'b1;
                           bm_wa  = r_clr[CW-1:0];
                           bm_wd  = '0;
                       end
            S_IDLE:    if (i_in.valid && i_in.ready && i_in.cmd == CMD_LOAD) begin
                           mem_we = 1'b1;
                           mem_wa = i_in.load_address;
                           mem_wd = {i_in.load_value[19], i_in.load_value};
                       end
            S_MARK:    bm_we = (r_mleft != 2'd0) && (r_mleft != 2'd3);
            S_WRENTRY: mem_we = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR:   r_clr <= r_clr + AW'(1);
                S_IDLE:    if (i_in.valid && i_in.ready) begin
                               r_cmd   <= i_in.cmd;
                               r_page  <= i_in.page;
                               r_off   <= i_in.offset;
                               r_lvl   <= 1'b0;
                               r_addr  <= AW'(i_in.segment);
                               r_ostat <= ST_OK;
                               r_opa   <= '0;
                               r_mfr   <= i_in.frame_number;
                               r_mleft <= 2'd3;
                           end
                S_CHECK:   begin
                               if (e == {EW{1'b1}}) r_ostat <= ST_FAULT;
                               else if (e == '0) begin
                                   if (r_cmd != CMD_WRITE) r_ostat <= ST_ERROR;
                                   r_chunk <= '0;
                                   r_bit   <= '0;
                                   r_run   <= '0;
                               end else if (!r_lvl) begin
                                   r_lvl  <= 1'b1;
                                   r_addr <= ebase + AW'(r_page);
                               end else begin
                                   r_opa <= ebase + AW'(r_off);
                               end
                           end
                S_SCANBIT: begin
                               r_run <= bit_free ? r_run + 2'd1 : 2'd0;
                               if (bit_free && (r_run + 2'd1 == need)) begin
                                   r_first <= cur_frame - FW'(r_run);
                                   r_mfr   <= cur_frame - FW'(r_run);
                                   r_mleft <= need + 2'd1;
                               end else begin
                                   r_bit <= r_bit + BW'(1);
                                   if (r_bit == BW'(CHUNK - 1)) begin
                                       r_chunk <= r_chunk + CW'(1);
                                       if (r_chunk == CW'(NCHUNK - 1)) r_ostat <= ST_NOSPACE;
                                   end
                               end
                           end
                S_MARK:    begin
                               if (r_cmd == CMD_MARK) begin
                                   // single frame: 3 read, 2 and 1 write, 0 done
                                   r_mleft <= (r_mleft == 2'd3) ? 2'd2 : r_mleft - 2'd1;
                               end else if (r_mleft == 2'd3 || r_mleft == 2'd2) begin
                                   if (r_mleft == 2'd3) r_mleft <= 2'd2;
                                   else r_mleft <= 2'd1;
                               end else if (r_mleft == 2'd1) begin
                                   r_mleft <= 2'd0;
                               end
                               if (bm_we && r_cmd != CMD_MARK && r_mfr != r_first + FW'(need - 2'd1))
                               begin
                                   r_mfr   <= r_mfr + FW'(1);
                                   r_mleft <= 2'd3;
                               end
                           end
                S_WRENTRY: begin
                               if (!r_lvl) begin
                                   r_lvl  <= 1'b1;
                                   r_addr <= {r_first, OW'(0)} + AW'(r_page);
                               end else begin
                                   r_opa <= {r_first, OW'(0)} + AW'(r_off);
                               end
                           end
                S_DONE:    begin
                               r_ovalid <= 1'b1;
                               if (r_ostat != ST_OK) r_opa <= '0;
                           end
                default:   ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/tlfa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlfa_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [1:0] i_out_status,
    input wire logic [18:0] i_out_pa
);
    import tlfa_pkg::*;

    a_no_ready_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken with result pending");
    a_pa_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> i_out_pa == '0)
        else $error("address on failure");
    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("ready after accept");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("result dropped");
endmodule

bind two_level_translate_with_frame_alloc_unit tlfa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_status(o_out.status), .i_out_pa(o_out.physical_address)
);
`default_nettype wire

[dv/two_level_translate_with_frame_alloc_unit_tb.sv]
`timescale 1ns / 1ps
module two_level_translate_with_frame_alloc_unit_tb;
    import tlfa_pkg::*;

    localparam int CYCLE_LIMIT = 15_000_000;
    localparam int LONG_HOLD   = 400;
    localparam logic [EW-1:0] NOT_RESIDENT = '1;

    typedef struct {
        t_cmd               cmd;
        logic [8:0]         segment;
        logic [9:0]         page;
        logic [8:0]         offset;
        logic [18:0]        load_address;
        logic signed [19:0] load_value;
        logic [9:0]         frame_number;
    } t_request;

    typedef struct {
        t_status     status;
        logic [18:0] physical_address;
    } t_translation;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlfa_in_if  req_if ();
    tlfa_out_if rsp_if ();

    two_level_translate_with_frame_alloc_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (rsp_if.source)
    );

    always #1 i_clk = ~i_clk;

    logic [EW-1:0] mem_model [int];
    bit            frame_taken [FRAME_COUNT];
    t_translation  pending_results [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            burst_left = 0;
    bit            long_hold_req = 0;
    int            hold_left = 0;

    function automatic logic [EW-1:0] mem_read(int addr);
        return mem_model.exists(addr) ? mem_model[addr] : '0;
    endfunction

    function automatic bit claim_frames(int n, output int base);
        int run;
        run = 0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            run = frame_taken[i] ? 0 : run + 1;
            if (run == n) begin
                for (int k = i + 1 - n; k <= i; k++) frame_taken[k] = 1;
                base = (i + 1 - n) * WORDS_PER_FRAME;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic int free_frames();
        int n;
        n = 0;
        for (int i = 0; i < FRAME_COUNT; i++) if (!frame_taken[i]) n++;
        return n;
    endfunction

    function automatic int find_zero_segment();
        for (int s = 16; s < 512; s++) if (mem_read(s) == '0) return s;
        return -1;
    endfunction

    function automatic t_status walk_entry(int addr, bit alloc, int n, output int base);
        logic [EW-1:0] e;
        int b;
        e = mem_read(addr);
        base = 0;
        if (e == NOT_RESIDENT) return ST_FAULT;
        if (e == '0) begin
            if (!alloc) return ST_ERROR;
            if (!claim_frames(n, b)) return ST_NOSPACE;
            mem_model[addr] = EW'(b);
            base = b;
            return ST_OK;
        end
        base = int'(e);
        return ST_OK;
    endfunction

    function automatic t_translation predict_translation(t_request r);
        t_translation res;
        int pt, data;
        res.status = ST_OK;
        res.physical_address = '0;
        case (r.cmd)
            CMD_LOAD: mem_model[int'(r.load_address)] = EW'(r.load_value);
            CMD_MARK: frame_taken[r.frame_number] = 1;
            default: begin
                res.status = walk_entry(int'(r.segment), r.cmd == CMD_WRITE,
                                        FRAMES_PER_TABLE, pt);
                if (res.status == ST_OK)
                    res.status = walk_entry((pt + int'(r.page)) % MEM_WORDS,
                                            r.cmd == CMD_WRITE, 1, data);
                if (res.status == ST_OK)
                    res.physical_address = 19'(data + int'(r.offset));
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(t_request r);
        req_if.valid        <= 1'b1;
        req_if.cmd          <= r.cmd;
        req_if.segment      <= r.segment;
        req_if.page         <= r.page;
        req_if.offset       <= r.offset;
        req_if.load_address <= r.load_address;
        req_if.load_value   <= r.load_value;
        req_if.frame_number <= r.frame_number;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_translation(r));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_request random_request();
        t_request r;
        r.cmd          = t_cmd'($urandom_range(0, 3));
        r.segment      = 9'($urandom);
        r.page         = 10'($urandom);
        r.offset       = 9'($urandom);
        r.load_address = 19'($urandom);
        r.load_value   = 20'($urandom_range(0, 524288)) - 20'sd1;
        r.frame_number = 10'($urandom);
        return r;
    endfunction

    function automatic logic signed [19:0] entry_value();
        case ($urandom_range(0, 5))
            0: return -20'sd1;
            1: return 20'sd0;
            2: return 20'($urandom_range(0, 524287));
            default: return 20'($urandom_range(1, FRAME_COUNT - 1) * WORDS_PER_FRAME);
        endcase
    endfunction

    function automatic t_request shaped_request();
        t_request r;
        int pick, base;
        r = random_request();
        r.segment = 9'($urandom_range(0, 15));
        r.page    = 10'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            r.cmd          = CMD_LOAD;
            r.load_address = 19'(r.segment);
            r.load_value   = entry_value();
        end else if (pick < 40) begin
            base           = int'(mem_read(int'(r.segment)));
            r.cmd          = CMD_LOAD;
            r.load_address = 19'(base + int'(r.page));
            r.load_value   = entry_value();
        end else if (pick < 80) begin
            r.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        end else if (pick < 85) begin
            r.cmd = CMD_MARK;
        end else begin
            r = random_request();
        end
        return r;
    endfunction

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_request r;
        r = random_request();
        r.segment = 9'd0; r.page = 10'd0; r.offset = 9'd0;
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_WRITE; send_request(r);
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_LOAD; r.load_address = 19'd5; r.load_value = -20'sd1; send_request(r);
        r.segment = 9'd5;
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_WRITE; send_request(r);
        r.cmd = CMD_LOAD; r.load_address = 19'd6; r.load_value = 20'sh80000; send_request(r);
        r.segment = 9'd6; r.page = 10'h3FF; r.offset = 9'h1FF;
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_LOAD; r.load_address = 19'h7FFFF; r.load_value = 20'sd524287;
        send_request(r);
        r.cmd = CMD_LOAD; r.load_address = 19'h1FF; r.load_value = 20'sd524287;
        send_request(r);
        r.segment = 9'h1FF;
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_WRITE; send_request(r);
        r.cmd = CMD_READ;  send_request(r);
        r.cmd = CMD_MARK; r.frame_number = 10'h3FF; send_request(r);
        r.frame_number = 10'd0; send_request(r);
        r.cmd = CMD_WRITE; r.segment = 9'd9; r.page = 10'd3; r.offset = 9'd77; send_request(r);
        r.cmd = CMD_READ; send_request(r);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_request(shaped_request());
        wait_drained();
    endtask

    task automatic test_backpressure();
        long_hold_req = 1;
        for (int i = 0; i < 40; i++) send_request(shaped_request());
        wait_drained();
    endtask

    task automatic test_exhaustion();
        t_request r;
        int pair, seg;
        r = random_request();
        r.page = 10'd1; r.offset = 9'd3;
        r.cmd = CMD_WRITE;
        for (int s = 16; s < 512 && free_frames() > 40; s++) begin
            if (mem_read(s) == '0) begin
                r.segment = 9'(s);
                send_request(r);
            end
        end
        pair = -1;
        for (int f = FRAME_COUNT - 2; f >= 0 && pair < 0; f--) begin
            if (!frame_taken[f] && !frame_taken[f + 1]) pair = f;
        end
        r.cmd = CMD_MARK;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            if (!frame_taken[f] && (pair < 0 || (f != pair && f != pair + 1))) begin
                r.frame_number = 10'(f);
                send_request(r);
            end
        end
        seg = find_zero_segment();
        if (seg >= 0) begin
            r.segment = 9'(seg);
            r.cmd = CMD_WRITE; send_request(r);
            r.cmd = CMD_READ;  send_request(r);
        end
        seg = find_zero_segment();
        if (seg >= 0) begin
            r.segment = 9'(seg);
            r.cmd = CMD_WRITE; send_request(r);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (long_hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if ((cycle_count / 300) % 3 == 0) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_translation want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", rsp_if.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.physical_address !== want.physical_address)
                    report_mismatch("physical_address", rsp_if.physical_address,
                                    want.physical_address);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("two_level_translate_with_frame_alloc_unit_tb failed");
            $finish;
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_READ;
        req_if.segment      = '0;
        req_if.page         = '0;
        req_if.offset       = '0;
        req_if.load_address = '0;
        req_if.load_value   = '0;
        req_if.frame_number = '0;
        rsp_if.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(190);
        test_backpressure();
        test_random(190);
        test_exhaustion();
        req_if.valid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("two_level_translate_with_frame_alloc_unit_tb passed");
        end else begin
            $display("two_level_translate_with_frame_alloc_unit_tb failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/tlfa_pkg.sv
rtl/tlfa_if.sv
rtl/two_level_translate_with_frame_alloc_unit.sv
rtl/tlfa_checker.sv
dv/two_level_translate_with_frame_alloc_unit_tb.sv
